### hdl/qpn_pkg.sv
// Package for the normalized quaternion product unit.
// It holds the widths, the queue depth and the word type that passes from front to back.
// It depends on nothing else.
`default_nettype none
package qpn_pkg;
    // Fraction bits of the fixed-point components.
    localparam int FRAC_BITS = 28;
    localparam int DATA_W    = 32;
    // Products and signed sums of four products.
    localparam int MUL_W     = 2 * DATA_W;
    localparam int TERM_W    = MUL_W + 1;
    localparam int SUM_W     = MUL_W + 2;
    // Bit length of a magnitude, and the scaled component width.
    localparam int SH_W      = $clog2(SUM_W + 1);
    localparam int Q_W       = DATA_W - 1;
    localparam int Q2_W      = 2 * Q_W;
    localparam int S_W       = 64;
    localparam int REM_W     = S_W + 1;
    // Quotient of q^2 * 2^(2F) / S, and its square root.
    localparam int QUO_W     = 2 * FRAC_BITS + 1;
    localparam int M_W       = FRAC_BITS + 1;
    localparam int SQ_W      = 2 * FRAC_BITS + 2;
    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One scaled product: four magnitudes and their signs.
    typedef struct packed {
        logic [3:0]          neg;
        logic [3:0][Q_W-1:0] q;
    } t_qitem;
endpackage
`default_nettype wire

### hdl/qpn_front.sv
// Front of the unit: accepts quaternion pairs, forms the Hamilton product and scales it.
// Depends on qpn_pkg.
`default_nettype none
module qpn_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [3:0][qpn_pkg::DATA_W-1:0] i_a,
    input  logic [3:0][qpn_pkg::DATA_W-1:0] i_b,
    output logic                           o_push,
    output qpn_pkg::t_qitem                o_item,
    input  logic                           i_qfull
);
    import qpn_pkg::*;

    localparam int NSTG = 6;
    // Bit k is set when term k of component c is subtracted.
    localparam logic [3:0] NEG_TERM [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    logic [NSTG-1:0]              r_fv;
    logic signed [MUL_W-1:0]      r_p   [4][4];
    logic signed [SUM_W-1:0]      r_h   [4][2];
    logic signed [SUM_W-1:0]      r_s   [4];
    logic [SUM_W-1:0]             r_mag [4];
    logic [SUM_W-1:0]             r_mag2[4];
    logic [SUM_W-1:0]             r_or;
    logic [SH_W-1:0]              r_sh;
    logic [3:0]                   r_neg4, r_neg5;
    t_qitem                       r_item;
    logic signed [TERM_W-1:0]     w_term[4][4];
    logic [SUM_W-1:0]             w_or;
    logic [SH_W-1:0]              w_len;
    logic [SH_W-1:0]              w_sh;
    logic                         w_en;

    // The whole front moves unless its last word cannot enter the queue.
    assign w_en   = !(r_fv[NSTG-1] && i_qfull);
    assign o_full = !w_en;
    assign o_push = r_fv[NSTG-1] && !i_qfull;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[NSTG-2:0], i_push};
        end
    end

    // Signed terms of each component, picked by the Hamilton index pattern.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                w_term[c][k] = NEG_TERM[c][k]
                    ? -TERM_W'(r_p[k][2'(k) ^ 2'(c)])
                    :  TERM_W'(r_p[k][2'(k) ^ 2'(c)]);
            end
        end
    end

    // Bit length of the largest magnitude gives the common right shift.
    always_comb begin
        w_len = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (r_or[i]) begin
                w_len = SH_W'(i + 1);
            end
        end
        w_sh = (w_len > SH_W'(Q_W)) ? w_len - SH_W'(Q_W) : '0;
    end

    always_comb begin
        w_or = '0;
        for (int c = 0; c < 4; c++) begin
            w_or = w_or | (r_s[c][SUM_W-1] ? SUM_W'(-r_s[c]) : SUM_W'(r_s[c]));
        end
    end

    // Datapath stages: products, pair sums, sums, magnitudes, shift amount, scaling.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p[i][j] <= $signed(i_a[i]) * $signed(i_b[j]);
                end
            end
            for (int c = 0; c < 4; c++) begin
                r_h[c][0] <= SUM_W'(w_term[c][0]) + SUM_W'(w_term[c][1]);
                r_h[c][1] <= SUM_W'(w_term[c][2]) + SUM_W'(w_term[c][3]);
                r_s[c]    <= r_h[c][0] + r_h[c][1];
                r_mag[c]  <= r_s[c][SUM_W-1] ? SUM_W'(-r_s[c]) : SUM_W'(r_s[c]);
                r_neg4[c] <= r_s[c][SUM_W-1];
                r_mag2[c] <= r_mag[c];
                r_item.q[c] <= Q_W'(r_mag2[c] >> r_sh);
            end
            r_or       <= w_or;
            r_sh       <= w_sh;
            r_neg5     <= r_neg4;
            r_item.neg <= r_neg5;
        end
    end
endmodule
`default_nettype wire

### hdl/qpn_queue.sv
// Short queue that decouples the front from the back.
// Depends on qpn_pkg.
`default_nettype none
module qpn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qpn_pkg::t_qitem i_data,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output qpn_pkg::t_qitem o_data
);
    import qpn_pkg::*;

    t_qitem              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

### hdl/qpn_back.sv
// Back of the unit: sum of squares, long division and square root, one bit per stage.
// Depends on qpn_pkg.
`default_nettype none
module qpn_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  qpn_pkg::t_qitem                 i_item,
    output logic                            o_take,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [3:0][qpn_pkg::DATA_W-1:0] o_r
);
    import qpn_pkg::*;

    typedef struct packed {
        logic [3:0][S_W-1:0]   rem;
        logic [3:0][QUO_W-1:0] quo;
        logic [S_W-1:0]        s;
        logic [3:0]            neg;
        logic                  zero;
    } t_div;

    typedef struct packed {
        logic [3:0][QUO_W-1:0] qv;
        logic [3:0][M_W-1:0]   m;
        logic [3:0][SQ_W-1:0]  sq;
        logic [3:0]            neg;
        logic                  zero;
    } t_sq;

    // Squares and sum, division stages, root hand-off, root stages, output.
    localparam int NB = 2 + QUO_W + 1 + M_W + 1;

    logic [NB-1:0]          r_bv;
    logic [3:0][Q2_W-1:0]   r_q2;
    logic [3:0]             r_neg1;
    t_div                   r_dv [QUO_W+1];
    t_div                   n_dv [QUO_W+1];
    t_sq                    r_sq [M_W+1];
    t_sq                    n_sq [M_W+1];
    logic [3:0][DATA_W-1:0] r_out;
    logic                   w_en;

    // Every stage moves unless the result waits untaken.
    assign w_en    = !r_bv[NB-1] || i_pop;
    assign o_take  = w_en && i_valid;
    assign o_empty = !r_bv[NB-1];
    assign o_r     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[NB-2:0], i_valid};
        end
    end

    // Squares, then their sum, which seeds the division.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_q2[c] <= Q2_W'(i_item.q[c]) * Q2_W'(i_item.q[c]);
                r_dv[0].rem[c] <= S_W'(r_q2[c]);
                r_dv[0].quo[c] <= '0;
            end
            r_neg1       <= i_item.neg;
            r_dv[0].s    <= S_W'(r_q2[0]) + S_W'(r_q2[1]) + S_W'(r_q2[2]) + S_W'(r_q2[3]);
            r_dv[0].neg  <= r_neg1;
            r_dv[0].zero <= (r_q2 == '0);
        end
    end

    assign n_dv[0] = r_dv[0];

    // Restoring division of q^2 * 2^(2F) by S, one quotient bit per stage.
    for (genvar g = 1; g <= QUO_W; g++) begin : g_div
        always_comb begin
            logic [REM_W-1:0] t;
            n_dv[g] = r_dv[g-1];
            for (int c = 0; c < 4; c++) begin
                t = (g == 1) ? {1'b0, r_dv[g-1].rem[c]} : {r_dv[g-1].rem[c], 1'b0};
                if (t >= {1'b0, r_dv[g-1].s}) begin
                    n_dv[g].rem[c] = S_W'(t - {1'b0, r_dv[g-1].s});
                    n_dv[g].quo[c] = {r_dv[g-1].quo[c][QUO_W-2:0], 1'b1};
                end else begin
                    n_dv[g].rem[c] = S_W'(t);
                    n_dv[g].quo[c] = {r_dv[g-1].quo[c][QUO_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    // Hand the quotient to the root stages.
    always_comb begin
        n_sq[0].qv   = r_dv[QUO_W].quo;
        n_sq[0].m    = '0;
        n_sq[0].sq   = '0;
        n_sq[0].neg  = r_dv[QUO_W].neg;
        n_sq[0].zero = r_dv[QUO_W].zero;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0] <= n_sq[0];
        end
    end

    // Integer square root, one result bit per stage; the square is kept alongside.
    for (genvar g = 1; g <= M_W; g++) begin : g_sqrt
        localparam int BIT = M_W - g;
        always_comb begin
            logic [SQ_W-1:0] trial;
            n_sq[g] = r_sq[g-1];
            for (int c = 0; c < 4; c++) begin
                trial = r_sq[g-1].sq[c] + (SQ_W'(r_sq[g-1].m[c]) << (BIT + 1))
                      + (SQ_W'(1) << (2 * BIT));
                if (trial <= SQ_W'(r_sq[g-1].qv[c])) begin
                    n_sq[g].m[c]  = r_sq[g-1].m[c] | (M_W'(1) << BIT);
                    n_sq[g].sq[c] = trial;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[g] <= n_sq[g];
            end
        end
    end

    // Apply the signs; a zero product gives zero.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                if (r_sq[M_W].zero) begin
                    r_out[c] <= '0;
                end else if (r_sq[M_W].neg[c]) begin
                    r_out[c] <= -DATA_W'(r_sq[M_W].m[c]);
                end else begin
                    r_out[c] <= DATA_W'(r_sq[M_W].m[c]);
                end
            end
        end
    end
endmodule
`default_nettype wire

### hdl/quaternion_product_normalized_unit.sv
// Top level of the normalized quaternion product unit.
// Depends on qpn_pkg, qpn_front, qpn_queue and qpn_back.
//
//  channel | handshake        | word
//  --------+------------------+-----------------------------------------
//  input   | push / full      | i_a_w i_a_x i_a_y i_a_z i_b_w i_b_x i_b_y i_b_z
//  result  | empty / pop      | o_r_w o_r_x o_r_y o_r_z
//
// One word is accepted per cycle while full is low; results pass through the front, the queue
// and the one-bit-per-stage divider and square-root stages in the back.
// Reset is synchronous and active low; it clears the valid bits, queue pointers and fill count only.
// A stalled result holds the back; the queue lets the front keep taking words until it fills.
`default_nettype none
module quaternion_product_normalized_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_w,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_x,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_y,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_z,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_w,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_x,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_y,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_z,
    output logic                       empty,
    input  logic                       pop,
    output logic [qpn_pkg::DATA_W-1:0] o_r_w,
    output logic [qpn_pkg::DATA_W-1:0] o_r_x,
    output logic [qpn_pkg::DATA_W-1:0] o_r_y,
    output logic [qpn_pkg::DATA_W-1:0] o_r_z
);
    import qpn_pkg::*;

    logic                   w_qpush, w_qfull, w_qempty, w_take;
    t_qitem                 w_qin, w_qout;
    logic [3:0][DATA_W-1:0] w_r;

    qpn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_a     ({i_a_z, i_a_y, i_a_x, i_a_w}),
        .i_b     ({i_b_z, i_b_y, i_b_x, i_b_w}),
        .o_push  (w_qpush),
        .o_item  (w_qin),
        .i_qfull (w_qfull)
    );

    qpn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_data  (w_qin),
        .o_full  (w_qfull),
        .o_empty (w_qempty),
        .i_pop   (w_take),
        .o_data  (w_qout)
    );

    qpn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_qempty),
        .i_item  (w_qout),
        .o_take  (w_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_r     (w_r)
    );

    assign o_r_w = w_r[0];
    assign o_r_x = w_r[1];
    assign o_r_y = w_r[2];
    assign o_r_z = w_r[3];
endmodule
`default_nettype wire

### dv/qpn_checker.sv
// Result checker for the normalized quaternion product unit.
// It watches both queue-style channels, predicts each result word and compares it.
// It depends on qpn_pkg for the component width and the fraction bits.
`timescale 1ns / 1ps
module qpn_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_w,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_x,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_y,
    input  logic [qpn_pkg::DATA_W-1:0] i_a_z,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_w,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_x,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_y,
    input  logic [qpn_pkg::DATA_W-1:0] i_b_z,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [qpn_pkg::DATA_W-1:0] i_r_w,
    input  logic [qpn_pkg::DATA_W-1:0] i_r_x,
    input  logic [qpn_pkg::DATA_W-1:0] i_r_y,
    input  logic [qpn_pkg::DATA_W-1:0] i_r_z,
    output int                         o_fail_count,
    output int                         o_pending
);
    import qpn_pkg::*;

    typedef logic [3:0][DATA_W-1:0] t_quat;

    t_quat unit_products[$];

    // Exact Hamilton product, scaled down to 31-bit magnitudes, then each
    // component divided by the norm with rounding toward zero.
    function automatic t_quat unit_product(t_quat a, t_quat b);
        longint aw, ax, ay, az, bw, bx, by, bz;
        logic signed [127:0] prod [4];
        logic [127:0] mag [4];
        logic [63:0] mag_q [4];
        logic [63:0] norm_sq;
        logic [127:0] target, trial;
        logic [63:0] root, cand;
        int len, max_len, shift;
        t_quat res;
        aw = longint'($signed(a[0])); ax = longint'($signed(a[1]));
        ay = longint'($signed(a[2])); az = longint'($signed(a[3]));
        bw = longint'($signed(b[0])); bx = longint'($signed(b[1]));
        by = longint'($signed(b[2])); bz = longint'($signed(b[3]));
        prod[0] = 128'(aw * bw) - 128'(ax * bx) - 128'(ay * by) - 128'(az * bz);
        prod[1] = 128'(aw * bx) + 128'(ax * bw) + 128'(ay * bz) - 128'(az * by);
        prod[2] = 128'(aw * by) - 128'(ax * bz) + 128'(ay * bw) + 128'(az * bx);
        prod[3] = 128'(aw * bz) + 128'(ax * by) - 128'(ay * bx) + 128'(az * bw);
        // The largest bit length sets one common shift for all four.
        max_len = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = prod[i][127] ? -prod[i] : prod[i];
            len = 0;
            for (int k = 0; k < 128; k++) if (mag[i][k]) len = k + 1;
            if (len > max_len) max_len = len;
        end
        shift = (max_len > 31) ? max_len - 31 : 0;
        norm_sq = 0;
        for (int i = 0; i < 4; i++) begin
            mag_q[i] = 64'(mag[i] >> shift);
            norm_sq += mag_q[i] * mag_q[i];
        end
        // Bitwise search for the largest m with m^2 * S <= q^2 * 2^(2F).
        for (int i = 0; i < 4; i++) begin
            root = 0;
            if (norm_sq != 0) begin
                target = 128'(mag_q[i] * mag_q[i]) << (2 * FRAC_BITS);
                for (int bit_idx = FRAC_BITS; bit_idx >= 0; bit_idx--) begin
                    cand  = root | (64'd1 << bit_idx);
                    trial = 128'(cand * cand) * 128'(norm_sq);
                    if (trial <= target) root = cand;
                end
            end
            res[i] = prod[i][127] ? -root[DATA_W-1:0] : root[DATA_W-1:0];
        end
        return res;
    endfunction

    assign o_pending = unit_products.size();

    // Predict on each accepted input word and compare each accepted result word.
    always @(posedge i_clk) begin
        t_quat want, got;
        int errs;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (push && !full) begin
                unit_products.push_back(unit_product({i_a_z, i_a_y, i_a_x, i_a_w},
                                                     {i_b_z, i_b_y, i_b_x, i_b_w}));
            end
            if (pop && !empty) begin
                got = {i_r_z, i_r_y, i_r_x, i_r_w};
                if (unit_products.size() == 0) begin
                    $display("%0t: result word with none expected: w=%h x=%h y=%h z=%h",
                             $time, i_r_w, i_r_x, i_r_y, i_r_z);
                    errs++;
                end else begin
                    want = unit_products.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (want[i] !== got[i]) begin
                            $display("%0t: component %0d expected %h actual %h",
                                     $time, i, want[i], got[i]);
                            errs++;
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

### dv/tb.sv
// Testbench top for the normalized quaternion product unit.
// It drives directed and random quaternion pairs with random idling and a long result stall.
// It depends on qpn_pkg, the unit and qpn_checker.
`timescale 1ns / 1ps
module tb;
    import qpn_pkg::*;

    localparam int NUM_RANDOM  = 1500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 300;
    localparam logic [DATA_W-1:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic [DATA_W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty;
    logic [DATA_W-1:0] a_w = 0, a_x = 0, a_y = 0, a_z = 0;
    logic [DATA_W-1:0] b_w = 0, b_x = 0, b_y = 0, b_z = 0;
    logic [DATA_W-1:0] r_w, r_x, r_y, r_z;
    int fail_count, pending;
    int cycle = 0;

    always #5 i_clk = ~i_clk;

    quaternion_product_normalized_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_a_w(a_w), .i_a_x(a_x), .i_a_y(a_y), .i_a_z(a_z),
        .i_b_w(b_w), .i_b_x(b_x), .i_b_y(b_y), .i_b_z(b_z),
        .empty(empty), .pop(pop),
        .o_r_w(r_w), .o_r_x(r_x), .o_r_y(r_y), .o_r_z(r_z)
    );

    qpn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_a_w(a_w), .i_a_x(a_x), .i_a_y(a_y), .i_a_z(a_z),
        .i_b_w(b_w), .i_b_x(b_x), .i_b_y(b_y), .i_b_z(b_z),
        .empty(empty), .pop(pop),
        .i_r_w(r_w), .i_r_x(r_x), .i_r_y(r_y), .i_r_z(r_z),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // No idling at all inside this window of cycles.
    function automatic bit busy_window();
        return cycle >= 1450 && cycle < 1750;
    endfunction

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random pops, plus one long hold-off so the unit fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
        end else if (cycle >= 1000 && cycle < 1400) begin
            pop <= 0;
        end else begin
            pop <= busy_window() || ($urandom_range(99) >= 10);
        end
    end

    // Offer one word and hold it until the unit takes it.
    task automatic send_word(logic [DATA_W-1:0] aw, ax, ay, az, bw, bx, by, bz);
        while (!busy_window() && $urandom_range(99) < 10) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        a_w <= aw; a_x <= ax; a_y <= ay; a_z <= az;
        b_w <= bw; b_x <= bx; b_y <= by; b_z <= bz;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // A component chosen at random: fully random, small, near one, or random shifted right.
    function automatic logic [DATA_W-1:0] rand_comp();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(15) - 8;
            2: return ONE + $urandom_range(255) - 128;
            default: return $signed($urandom()) >>> $urandom_range(31);
        endcase
    endfunction

    initial begin
        int zero_side;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed words: zero product, extremes, unit basis, small magnitudes.
        send_word(0, 0, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, 0, 0, MAXV, MINV, MAXV, MINV);
        send_word(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_word(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_word(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV);
        send_word(MINV, 0, 0, 0, MINV, 0, 0, 0);
        send_word(ONE, 0, 0, 0, ONE, 0, 0, 0);
        send_word(0, ONE, 0, 0, 0, ONE, 0, 0);
        send_word(0, 0, ONE, 0, 0, 0, ONE, 0);
        send_word(0, 0, 0, ONE, 0, 0, 0, ONE);
        send_word(0, ONE, 0, 0, 0, 0, ONE, 0);
        send_word(1, 0, 0, 0, 1, 0, 0, 0);
        send_word(1, 1, 1, 1, 1, 1, 1, 1);
        send_word(-1, 1, -1, 1, 1, -1, 1, -1);
        send_word(3, 0, 0, 4, 1, 0, 0, 0);
        send_word(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);
        send_word(MAXV, 1, 0, 0, MAXV, -1, 0, 0);
        send_word(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                  32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);

        // Random words, with an occasional all-zero side for zero products.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            zero_side = $urandom_range(19);
            send_word(zero_side == 0 ? 0 : rand_comp(), zero_side == 0 ? 0 : rand_comp(),
                      zero_side == 0 ? 0 : rand_comp(), zero_side == 0 ? 0 : rand_comp(),
                      zero_side == 1 ? 0 : rand_comp(), zero_side == 1 ? 0 : rand_comp(),
                      zero_side == 1 ? 0 : rand_comp(), zero_side == 1 ? 0 : rand_comp());
        end
        push <= 0;

        // Drain every expected word, then allow the pipeline latency to pass.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
